// ===== src/ibc_pkg.sv =====
// Shared constants for the I2C bus-clear sequencer.
package ibc_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int TIMER_WIDTH_DEF = 16;
  localparam int OUT_CNT_W       = 32;
  localparam int CFG_W           = 16;
  localparam int PULSE_W         = 4;
  localparam int COND_W          = 2;
  localparam int PADDR_W         = 4;
  localparam int PDATA_W         = 32;

  localparam logic [PULSE_W-1:0] PULSE_CAP    = 4'd9;
  localparam logic [CFG_W-1:0]   HALF_RESET   = 16'd5;
  localparam logic [CFG_W-1:0]   SETTLE_RESET = 16'd10;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_HALF   = 2'd0;
  localparam logic [1:0] REG_SETTLE = 2'd1;
  localparam logic [1:0] REG_PULSES = 2'd2;

  // bus classification
  localparam logic [COND_W-1:0] COND_IDLE = 2'd0;

  // sequencer phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_SETTLE   = 3'd1;
  localparam logic [2:0] PH_LOW      = 3'd2;
  localparam logic [2:0] PH_HIGH     = 3'd3;
  localparam logic [2:0] PH_STOP_SDA = 3'd4;
  localparam logic [2:0] PH_STOP_SCL = 3'd5;
  localparam logic [2:0] PH_STOP_END = 3'd6;

endpackage

// ===== src/ibc_if.sv =====
// Item channel interfaces: tick input and result output.
interface ibc_in_if;
  logic valid;
  logic ready;
  logic sda_level;
  logic scl_level;
  logic start_request;

  modport source (output valid, sda_level, scl_level, start_request, input ready);
  modport sink   (input valid, sda_level, scl_level, start_request, output ready);
endinterface

interface ibc_out_if;
  import ibc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 scl_pull_low;
  logic                 sda_pull_low;
  logic                 busy_res;
  logic                 done_res;
  logic                 outcome;
  logic [COND_W-1:0]    bus_condition;
  logic [OUT_CNT_W-1:0] recoveries;
  logic [OUT_CNT_W-1:0] timeouts;

  modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res, outcome,
                  bus_condition, recoveries, timeouts, input ready);
  modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, done_res, outcome,
                  bus_condition, recoveries, timeouts, output ready);
endinterface

// ===== src/i2c_bus_clear_sequencer_core.sv =====
// I2C bus-clear sequencer: up to nine SCL recovery pulses, one tick item per cycle unless the output stalls.
// The result of a tick item is written to the output register by the same edge that accepts it.
// Throughput: one item per cycle; the input stays ready while the output register is
// empty or being drained in the same cycle.
// Reset (synchronous, rst_n low): sequencer idle, lines released, counters zero,
// registers back to half period 5, settle 10, max pulses 9.
module i2c_bus_clear_sequencer_core #(
  parameter int COUNT_WIDTH = ibc_pkg::COUNT_WIDTH_DEF,
  parameter int TIMER_WIDTH = ibc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ibc_in_if.sink                      in_ch,
  ibc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ibc_pkg::PADDR_W-1:0] paddr,
  input  logic [ibc_pkg::PDATA_W-1:0] pwdata,
  output logic [ibc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import ibc_pkg::*;

  logic [CFG_W-1:0]       half_r, settle_r;
  logic [PULSE_W-1:0]     max_pulses_r;

  logic [2:0]             phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt;
  logic [PULSE_W-1:0]     pulses_r, pulses_nxt;
  logic [COND_W-1:0]      cond_r, cond_nxt;
  logic [COUNT_WIDTH-1:0] rec_r, rec_nxt;
  logic [COUNT_WIDTH-1:0] flt_r, flt_nxt;
  logic                   drv_scl_r, drv_scl_nxt;
  logic                   drv_sda_r, drv_sda_nxt;

  logic                   done_nxt, outcome_nxt;
  logic                   out_valid_r;
  logic                   in_acc;
  logic                   wr_en;

  logic [COND_W-1:0]      cond_now;
  logic [PULSE_W-1:0]     pulse_lim;
  logic                   wait_done;
  logic [TIMER_WIDTH-1:0] half_load, settle_load;

  function automatic logic [TIMER_WIDTH-1:0] load_val(input logic [CFG_W-1:0] ticks);
    logic [TIMER_WIDTH-1:0] v;
    v = TIMER_WIDTH'(ticks);
    if (v == '0) begin
      v = TIMER_WIDTH'(1);
    end
    return v;
  endfunction

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r       <= HALF_RESET;
      settle_r     <= SETTLE_RESET;
      max_pulses_r <= PULSE_CAP;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_HALF:   half_r       <= pwdata[CFG_W-1:0];
        REG_SETTLE: settle_r     <= pwdata[CFG_W-1:0];
        REG_PULSES: max_pulses_r <= pwdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HALF:   prdata = PDATA_W'(half_r);
      REG_SETTLE: prdata = PDATA_W'(settle_r);
      REG_PULSES: prdata = PDATA_W'(max_pulses_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------- sequencer next state ----------------
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;

  // bit 0: SDA stuck low, bit 1: SCL stuck low
  assign cond_now    = {!in_ch.scl_level, !in_ch.sda_level};
  assign pulse_lim   = (max_pulses_r > PULSE_CAP) ? PULSE_CAP : max_pulses_r;
  assign wait_done   = (timer_r <= TIMER_WIDTH'(1));
  assign half_load   = load_val(half_r);
  assign settle_load = load_val(settle_r);

  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    pulses_nxt  = pulses_r;
    cond_nxt    = cond_r;
    rec_nxt     = rec_r;
    flt_nxt     = flt_r;
    drv_scl_nxt = drv_scl_r;
    drv_sda_nxt = drv_sda_r;
    done_nxt    = 1'b0;
    outcome_nxt = 1'b0;

    if (phase_r != PH_IDLE && !wait_done) begin
      timer_nxt = timer_r - TIMER_WIDTH'(1);
    end

    case (phase_r)
      PH_IDLE: begin
        if (in_ch.start_request) begin
          cond_nxt = cond_now;
          if (cond_now == COND_IDLE) begin
            done_nxt = 1'b1;
          end else begin
            drv_scl_nxt = 1'b0;
            drv_sda_nxt = 1'b0;
            pulses_nxt  = '0;
            timer_nxt   = settle_load;
            phase_nxt   = PH_SETTLE;
          end
        end
      end
      PH_SETTLE, PH_HIGH: begin
        if (wait_done) begin
          timer_nxt = half_load;
          if (!(in_ch.sda_level && in_ch.scl_level) && pulses_r < pulse_lim) begin
            pulses_nxt  = pulses_r + PULSE_W'(1);
            drv_scl_nxt = 1'b1;
            drv_sda_nxt = 1'b0;
            phase_nxt   = PH_LOW;
          end else begin
            drv_scl_nxt = 1'b0;
            drv_sda_nxt = 1'b1;
            phase_nxt   = PH_STOP_SDA;
          end
        end
      end
      PH_LOW: begin
        if (wait_done) begin
          drv_scl_nxt = 1'b0;
          timer_nxt   = half_load;
          phase_nxt   = PH_HIGH;
        end
      end
      PH_STOP_SDA: begin
        if (wait_done) begin
          drv_scl_nxt = 1'b0;
          timer_nxt   = half_load;
          phase_nxt   = PH_STOP_SCL;
        end
      end
      PH_STOP_SCL: begin
        if (wait_done) begin
          drv_sda_nxt = 1'b0;
          timer_nxt   = settle_load;
          phase_nxt   = PH_STOP_END;
        end
      end
      PH_STOP_END: begin
        if (wait_done) begin
          cond_nxt = cond_now;
          done_nxt = 1'b1;
          if (cond_now == COND_IDLE) begin
            if (rec_r != '1) begin
              rec_nxt = rec_r + COUNT_WIDTH'(1);
            end
          end else begin
            if (flt_r != '1) begin
              flt_nxt = flt_r + COUNT_WIDTH'(1);
            end
            outcome_nxt = 1'b1;
          end
          drv_scl_nxt = 1'b0;
          drv_sda_nxt = 1'b0;
          phase_nxt   = PH_IDLE;
        end
      end
      default: begin
        drv_scl_nxt = 1'b0;
        drv_sda_nxt = 1'b0;
        phase_nxt   = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      timer_r   <= '0;
      pulses_r  <= '0;
      cond_r    <= COND_IDLE;
      rec_r     <= '0;
      flt_r     <= '0;
      drv_scl_r <= 1'b0;
      drv_sda_r <= 1'b0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      pulses_r  <= pulses_nxt;
      cond_r    <= cond_nxt;
      rec_r     <= rec_nxt;
      flt_r     <= flt_nxt;
      drv_scl_r <= drv_scl_nxt;
      drv_sda_r <= drv_sda_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_ch.scl_pull_low  <= drv_scl_nxt;
      out_ch.sda_pull_low  <= drv_sda_nxt;
      out_ch.busy_res      <= (phase_nxt != PH_IDLE);
      out_ch.done_res      <= done_nxt;
      out_ch.outcome       <= outcome_nxt;
      out_ch.bus_condition <= cond_nxt;
      out_ch.recoveries    <= OUT_CNT_W'(rec_nxt);
      out_ch.timeouts      <= OUT_CNT_W'(flt_nxt);
    end
  end

  assign out_ch.valid = out_valid_r;

  // ---------------- assertions ----------------
  a_pulse_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pulses_r <= PULSE_CAP)
    else $error("pulse count above cap");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done result still busy");

  a_outcome_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.outcome |-> out_ch.done_res)
    else $error("fault outcome without done");

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> !drv_scl_r && !drv_sda_r)
    else $error("line driven while idle");

  a_scl_low_phase: assert property (@(posedge clk) disable iff (!rst_n)
    drv_scl_r |-> phase_r == PH_LOW)
    else $error("SCL driven outside low half period");

endmodule

// ===== bench/ibc_bus_clear_checker.sv =====
// Bus-clear sequencer checker: mirrors the tick sequencer and compares every result item.
module ibc_bus_clear_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  ibc_in_if                           in_mon,
  ibc_out_if                          out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ibc_pkg::PADDR_W-1:0] paddr,
  input  logic [ibc_pkg::PDATA_W-1:0] pwdata,
  output int                          fail_count,
  output int                          awaited,
  output logic                        seq_busy
);
  timeunit 1ns;
  timeprecision 1ps;
  import ibc_pkg::*;

  typedef struct packed {
    logic                 scl_pull_low;
    logic                 sda_pull_low;
    logic                 busy_res;
    logic                 done_res;
    logic                 outcome;
    logic [COND_W-1:0]    bus_condition;
    logic [OUT_CNT_W-1:0] recoveries;
    logic [OUT_CNT_W-1:0] timeouts;
  } tick_result_t;

  logic [CFG_W-1:0]           half_cfg;
  logic [CFG_W-1:0]           settle_cfg;
  logic [PULSE_W-1:0]         pulse_cfg;
  logic [2:0]                 phase;
  logic [TIMER_WIDTH_DEF-1:0] wait_left;
  logic [PULSE_W-1:0]         pulses;
  logic [COND_W-1:0]          cond_last;
  logic [OUT_CNT_W-1:0]       recov_cnt;
  logic [OUT_CNT_W-1:0]       fault_cnt;
  logic                       drive_scl;
  logic                       drive_sda;
  tick_result_t               awaited_results[$];
  int                         res_no;

  // a zero wait still takes one tick
  function automatic logic [TIMER_WIDTH_DEF-1:0] timer_load(input logic [CFG_W-1:0] ticks);
    logic [TIMER_WIDTH_DEF-1:0] v;
    v = TIMER_WIDTH_DEF'(ticks);
    return (v == '0) ? TIMER_WIDTH_DEF'(1) : v;
  endfunction

  function automatic logic timer_expired();
    if (wait_left <= 1) return 1'b1;
    wait_left = wait_left - 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [OUT_CNT_W-1:0] sat_inc(input logic [OUT_CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [COND_W-1:0] classify(input logic sda, input logic scl);
    return {~scl, ~sda};
  endfunction

  function automatic void pulse_or_stop(input logic sda, input logic scl);
    logic [PULSE_W-1:0] limit;
    limit = (pulse_cfg > PULSE_CAP) ? PULSE_CAP : pulse_cfg;
    if (!(sda && scl) && pulses < limit) begin
      pulses    = pulses + 1'b1;
      drive_scl = 1'b1;
      drive_sda = 1'b0;
      wait_left = timer_load(half_cfg);
      phase     = PH_LOW;
    end else begin
      drive_scl = 1'b0;
      drive_sda = 1'b1;
      wait_left = timer_load(half_cfg);
      phase     = PH_STOP_SDA;
    end
  endfunction

  function automatic tick_result_t step_sequencer(input logic sda, input logic scl,
                                                  input logic start);
    tick_result_t      r;
    logic              done;
    logic              fault;
    logic [COND_W-1:0] cond;
    done  = 1'b0;
    fault = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (start) begin
          cond      = classify(sda, scl);
          cond_last = cond;
          if (cond == COND_IDLE) begin
            done = 1'b1;
          end else begin
            drive_scl = 1'b0;
            drive_sda = 1'b0;
            pulses    = '0;
            wait_left = timer_load(settle_cfg);
            phase     = PH_SETTLE;
          end
        end
      end
      PH_SETTLE, PH_HIGH: begin
        if (timer_expired()) pulse_or_stop(sda, scl);
      end
      PH_LOW: begin
        if (timer_expired()) begin
          drive_scl = 1'b0;
          wait_left = timer_load(half_cfg);
          phase     = PH_HIGH;
        end
      end
      PH_STOP_SDA: begin
        if (timer_expired()) begin
          drive_scl = 1'b0;
          wait_left = timer_load(half_cfg);
          phase     = PH_STOP_SCL;
        end
      end
      PH_STOP_SCL: begin
        if (timer_expired()) begin
          drive_sda = 1'b0;
          wait_left = timer_load(settle_cfg);
          phase     = PH_STOP_END;
        end
      end
      PH_STOP_END: begin
        if (timer_expired()) begin
          cond      = classify(sda, scl);
          cond_last = cond;
          done      = 1'b1;
          if (cond == COND_IDLE) begin
            recov_cnt = sat_inc(recov_cnt);
          end else begin
            fault_cnt = sat_inc(fault_cnt);
            fault     = 1'b1;
          end
          drive_scl = 1'b0;
          drive_sda = 1'b0;
          phase     = PH_IDLE;
        end
      end
      default: begin
        drive_scl = 1'b0;
        drive_sda = 1'b0;
        phase     = PH_IDLE;
      end
    endcase
    r.scl_pull_low  = drive_scl;
    r.sda_pull_low  = drive_sda;
    r.busy_res      = (phase != PH_IDLE);
    r.done_res      = done;
    r.outcome       = fault;
    r.bus_condition = cond_last;
    r.recoveries    = recov_cnt;
    r.timeouts      = fault_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [OUT_CNT_W-1:0] got,
                                 input logic [OUT_CNT_W-1:0] want);
    $display("MISMATCH result item %0d %s: got %0h, expected %0h", res_no, field, got, want);
    fail_count++;
  endtask

  task automatic check_field(input string field, input logic [OUT_CNT_W-1:0] got,
                             input logic [OUT_CNT_W-1:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  always @(posedge clk) begin : watch
    tick_result_t want;
    if (!rst_n) begin
      half_cfg   = HALF_RESET;
      settle_cfg = SETTLE_RESET;
      pulse_cfg  = PULSE_CAP;
      phase      = PH_IDLE;
      wait_left  = '0;
      pulses     = '0;
      cond_last  = COND_IDLE;
      recov_cnt  = '0;
      fault_cnt  = '0;
      drive_scl  = 1'b0;
      drive_sda  = 1'b0;
      awaited_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_HALF:   half_cfg   = pwdata[CFG_W-1:0];
          REG_SETTLE: settle_cfg = pwdata[CFG_W-1:0];
          REG_PULSES: pulse_cfg  = pwdata[PULSE_W-1:0];
          default: ;
        endcase
      end
      // pop before push: a result leaving now belongs to an older item
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("item with none awaited", '0, '0);
        end else begin
          want = awaited_results.pop_front();
          check_field("scl_pull_low", OUT_CNT_W'(out_mon.scl_pull_low),
                      OUT_CNT_W'(want.scl_pull_low));
          check_field("sda_pull_low", OUT_CNT_W'(out_mon.sda_pull_low),
                      OUT_CNT_W'(want.sda_pull_low));
          check_field("busy_res", OUT_CNT_W'(out_mon.busy_res), OUT_CNT_W'(want.busy_res));
          check_field("done_res", OUT_CNT_W'(out_mon.done_res), OUT_CNT_W'(want.done_res));
          check_field("outcome", OUT_CNT_W'(out_mon.outcome), OUT_CNT_W'(want.outcome));
          check_field("bus_condition", OUT_CNT_W'(out_mon.bus_condition),
                      OUT_CNT_W'(want.bus_condition));
          check_field("recoveries", out_mon.recoveries, want.recoveries);
          check_field("timeouts", out_mon.timeouts, want.timeouts);
        end
        res_no++;
      end
      if (in_mon.valid && in_mon.ready) begin
        awaited_results.push_back(step_sequencer(in_mon.sda_level, in_mon.scl_level,
                                                 in_mon.start_request));
      end
    end
    awaited  <= awaited_results.size();
    seq_busy <= (phase != PH_IDLE);
  end

endmodule

// ===== bench/tb.sv =====
// Bench top for the bus-clear sequencer: clock, reset, tick and register stimulus, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ibc_pkg::*;

  localparam logic [1:0] REG_NONE    = 2'd3;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         PHASE_TICKS = 130;
  localparam int         NUM_PHASES  = 7;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 awaited;
  logic               seq_busy;
  logic               calm;
  int unsigned        res_hold = 0;
  int                 quiet_cycles = 0;
  int                 ticks_sent = 0;
  int                 starts_sent = 0;
  int                 reg_writes = 0;

  ibc_in_if  tick_ch();
  ibc_out_if res_ch();

  i2c_bus_clear_sequencer_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (tick_ch),
    .out_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ibc_bus_clear_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (tick_ch),
    .out_mon    (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .awaited    (awaited),
    .seq_busy   (seq_busy)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic level(input int unsigned p_high);
    return $urandom_range(0, 99) < p_high;
  endfunction

  always @(posedge clk) begin
    if (res_hold != 0) begin
      res_hold     <= res_hold - 1;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      res_hold     <= pick_gap();
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold the sender off until every awaited result item is out
  task automatic wait_results();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  task automatic send_tick(input logic sda, input logic scl, input logic start);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (!calm && $urandom_range(0, 199) == 0) begin
      wait_results();
    end else if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.sda_level     <= sda;
    tick_ch.scl_level     <= scl;
    tick_ch.start_request <= start;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
  endtask

  task automatic write_config(input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] settle,
                              input logic [PULSE_W-1:0] max_p);
    reg_write(REG_HALF, {CFG_W'($urandom()), half});
    reg_write(REG_SETTLE, {CFG_W'($urandom()), settle});
    reg_write(REG_PULSES, {(PDATA_W-PULSE_W)'($urandom()), max_p});
    if ($urandom_range(0, 2) == 0) reg_write(REG_NONE, $urandom());
  endtask

  // ticks with start low until the sequencer is idle and nothing is awaited
  task automatic drain_to_idle();
    wait_results();
    while (seq_busy) begin
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
      wait_results();
    end
  endtask

  task automatic run_recovery(input int unsigned p_high, input logic [COND_W-1:0] kind);
    send_tick(~kind[0], ~kind[1], 1'b1);
    starts_sent++;
    do begin
      send_tick(level(p_high), level(p_high), $urandom_range(0, 24) == 0);
    end while (seq_busy);
  endtask

  initial begin
    int                unsigned stop_at;
    int                unsigned p_high;
    logic [COND_W-1:0] kind;
    rst_n                 = 1'b0;
    calm                  = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    tick_ch.valid         = 1'b0;
    tick_ch.sda_level     = 1'b1;
    tick_ch.scl_level     = 1'b1;
    tick_ch.start_request = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(1'b1, 1'b1, 1'b0);
    // clean bus on start finishes at once
    send_tick(1'b1, 1'b1, 1'b1);
    starts_sent++;
    wait_results();
    // zero waits, over-range pulse count, junk in the upper data bits
    reg_write(REG_HALF, 32'hFFFF_0000);
    reg_write(REG_SETTLE, 32'h5A5A_0000);
    reg_write(REG_PULSES, 32'hFFFF_FFFF);
    reg_write(REG_NONE, 32'hFFFF_FFFF);
    // SDA held low through all pulses, start held high while busy
    send_tick(1'b0, 1'b1, 1'b1);
    starts_sent++;
    repeat (22) send_tick(1'b0, 1'b1, 1'b1);
    drain_to_idle();
    // stuck SCL that frees itself after the settle time
    send_tick(1'b1, 1'b0, 1'b1);
    starts_sent++;
    repeat (4) send_tick(1'b1, 1'b1, 1'b0);
    drain_to_idle();
    reg_write(REG_HALF, PDATA_W'(HALF_RESET));
    reg_write(REG_SETTLE, PDATA_W'(SETTLE_RESET));
    reg_write(REG_PULSES, PDATA_W'(PULSE_CAP));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        drain_to_idle();
        case (ph)
          1:       write_config(16'd1, 16'd1, 4'd9);
          2:       write_config(16'd2, 16'd3, 4'd0);
          default: write_config(CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 4)),
                                PULSE_W'($urandom_range(0, 15)));
        endcase
      end
      stop_at = ticks_sent + PHASE_TICKS;
      while (ticks_sent < stop_at) begin
        if ($urandom_range(0, 9) < 7) begin
          case ($urandom_range(0, 2))
            0:       p_high = 5;
            1:       p_high = 40;
            default: p_high = 85;
          endcase
          kind = ($urandom_range(0, 7) == 0) ? COND_IDLE : COND_W'($urandom_range(1, 3));
          run_recovery(p_high, kind);
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          end
        end
      end
    end

    // longer waits, no pulses, run back to back
    drain_to_idle();
    calm = 1'b1;
    write_config(16'd25, 16'd25, 4'd0);
    run_recovery(50, 2'd3);
    calm = 1'b0;

    wait_results();
    repeat (4) @(posedge clk);
    $display("covered %0d tick items, %0d recovery starts, %0d register writes",
             ticks_sent, starts_sent, reg_writes);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
